// File: design/pbl_pkg.sv
// Shared types and constants for the positional byte list.
package pbl_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W = 8;
	localparam int POS_W = 8;
	localparam int STATUS_W = 2;

	typedef enum logic [2:0] {
		ACT_APPEND    = 3'd0,
		ACT_FRONT     = 3'd1,
		ACT_AT_POS    = 3'd2,
		ACT_POP_BACK  = 3'd3,
		ACT_POP_FRONT = 3'd4
	} action_t;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_POS   = 2'd3;

	typedef struct packed {
		logic ins;
		logic pop_front;
	} cell_cmd_t;

endpackage

// File: design/pbl_req_if.sv
// Request channel: action, byte and insert position.
interface pbl_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] data_in;
	logic [7:0] position;

	modport source (output valid, action, data_in, position, input ready);
	modport sink (input valid, action, data_in, position, output ready);
endinterface

// File: design/pbl_rsp_if.sv
// Result channel: removed byte, status and element count.
interface pbl_rsp_if #(
	parameter int CNT_W = 5
);
	logic             valid;
	logic             ready;
	logic [7:0]       data_out;
	logic [1:0]       status;
	logic [CNT_W-1:0] count;

	modport source (output valid, data_out, status, count, input ready);
	modport sink (input valid, data_out, status, count, output ready);
endinterface

// File: design/positional_byte_list_top.sv
// Top level of the positional byte list.
// A request is held in the request register and its result in the result register.
// Throughput: one request per cycle while rsp.ready holds; each request is done in one
// pass through the decode and shift logic between the request and result registers.
// Reset clears the element count and both valid flags; cell contents stay
// undefined until written and are never read before that.
module positional_byte_list_top import pbl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pbl_req_if.sink   req,
	pbl_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                valid_s1;
	logic [2:0]          action_s1;
	logic [DATA_W-1:0]   data_s1;
	logic [POS_W-1:0]    position_s1;
	logic                out_valid_q;
	logic [DATA_W-1:0]   dout_q;
	logic [STATUS_W-1:0] status_q;
	logic [CNT_W-1:0]    count_out_q;
	logic                advance;

	cell_cmd_t           cmd;
	logic [IDX_W-1:0]    idx;
	logic [IDX_W-1:0]    back_idx;
	logic [CNT_W-1:0]    count;
	logic [DATA_W-1:0]   front;
	logic [DATA_W-1:0]   back;
	logic [DATA_W-1:0]   dout;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    count_next;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1   <= req.action;
			data_s1     <= req.data_in;
			position_s1 <= req.position;
		end
	end

	pbl_ctrl #(
		.CAPACITY(CAPACITY),
		.IDX_W   (IDX_W),
		.CNT_W   (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.action    (action_s1),
		.position  (position_s1),
		.front     (front),
		.back      (back),
		.cmd       (cmd),
		.idx       (idx),
		.back_idx  (back_idx),
		.count     (count),
		.dout      (dout),
		.status    (status),
		.count_next(count_next)
	);

	pbl_cells #(
		.CAPACITY(CAPACITY),
		.IDX_W   (IDX_W),
		.CNT_W   (CNT_W)
	) u_cells (
		.clk     (clk),
		.cmd     (cmd),
		.idx     (idx),
		.data    (data_s1),
		.count   (count),
		.back_idx(back_idx),
		.front   (front),
		.back    (back)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dout_q      <= dout;
			status_q    <= status;
			count_out_q <= count_next;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.data_out = dout_q;
	assign rsp.status   = status_q;
	assign rsp.count    = count_out_q;

endmodule

// File: design/pbl_cells.sv
// Row of byte cells that shift in parallel on insert and front removal.
module pbl_cells import pbl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int IDX_W = $clog2(CAPACITY),
	parameter int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [IDX_W-1:0]  idx,
	input  logic [DATA_W-1:0] data,
	input  logic [CNT_W-1:0]  count,
	input  logic [IDX_W-1:0]  back_idx,
	output logic [DATA_W-1:0] front,
	output logic [DATA_W-1:0] back
);

	logic [DATA_W-1:0] cell_q [CAPACITY];

	assign front = cell_q[0];
	assign back  = cell_q[back_idx];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (cmd.ins && idx == IDX_W'(0)) begin
					cell_q[i] <= data;
				end else if (cmd.pop_front && CNT_W'(i + 1) < count) begin
					cell_q[i] <= cell_q[i+1];
				end
			end
		end else if (i == CAPACITY - 1) begin : g_last
			always_ff @(posedge clk) begin
				if (cmd.ins && idx == IDX_W'(i)) begin
					cell_q[i] <= data;
				end else if (cmd.ins && IDX_W'(i) > idx && CNT_W'(i) <= count) begin
					cell_q[i] <= cell_q[i-1];
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (cmd.ins && idx == IDX_W'(i)) begin
					cell_q[i] <= data;
				end else if (cmd.ins && IDX_W'(i) > idx && CNT_W'(i) <= count) begin
					cell_q[i] <= cell_q[i-1];
				end else if (cmd.pop_front && CNT_W'(i + 1) < count) begin
					cell_q[i] <= cell_q[i+1];
				end
			end
		end
	end

endmodule

// File: design/pbl_ctrl.sv
// Request decode, insert index, status, and element count register.
module pbl_ctrl import pbl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int IDX_W = $clog2(CAPACITY),
	parameter int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [2:0]          action,
	input  logic [POS_W-1:0]    position,
	input  logic [DATA_W-1:0]   front,
	input  logic [DATA_W-1:0]   back,
	output cell_cmd_t           cmd,
	output logic [IDX_W-1:0]    idx,
	output logic [IDX_W-1:0]    back_idx,
	output logic [CNT_W-1:0]    count,
	output logic [DATA_W-1:0]   dout,
	output logic [STATUS_W-1:0] status,
	output logic [CNT_W-1:0]    count_next
);

	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             empty;
	logic [POS_W-1:0] pos_m1;
	logic [POS_W-1:0] cnt_ext;
	logic [POS_W-1:0] pos_idx;

	assign count    = count_q;
	assign full     = count_q == CNT_W'(CAPACITY);
	assign empty    = count_q == '0;
	assign pos_m1   = position - POS_W'(1);
	assign cnt_ext  = POS_W'(count_q);
	assign pos_idx  = (pos_m1 > cnt_ext) ? cnt_ext : pos_m1;
	assign back_idx = IDX_W'(count_q - CNT_W'(1));

	always_comb begin
		cmd        = '0;
		idx        = '0;
		dout       = '0;
		status     = ST_OK;
		count_next = count_q;
		case (action)
			ACT_APPEND, ACT_FRONT, ACT_AT_POS: begin
				if (action == ACT_AT_POS && position == '0) begin
					status = ST_POS;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					cmd.ins    = 1'b1;
					count_next = count_q + CNT_W'(1);
					case (action)
						ACT_APPEND: idx = IDX_W'(count_q);
						ACT_FRONT:  idx = '0;
						default:    idx = IDX_W'(pos_idx);
					endcase
				end
			end
			ACT_POP_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					dout       = back;
					count_next = count_q - CNT_W'(1);
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					cmd.pop_front = 1'b1;
					dout          = front;
					count_next    = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
		if (!fire) begin
			cmd = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_next;
		end
	end

endmodule
